FILE: hdl/dd_pkg.sv
// Package for the date difference block: payload types, status codes, calendar functions.
package dd_pkg;

  localparam int DayW   = 6;
  localparam int MonthW = 4;
  localparam int YearW  = 14;
  localparam int CountW = 22;
  localparam int QuotW  = 8;
  localparam logic [YearW-1:0] MaxYear = YearW'(9999);

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_START_BAD  = 2'd1,
    ST_FINISH_BAD = 2'd2,
    ST_ORDER      = 2'd3
  } status_t;

  typedef struct packed {
    logic [DayW-1:0]   start_day;
    logic [MonthW-1:0] start_month;
    logic [YearW-1:0]  start_year;
    logic [DayW-1:0]   finish_day;
    logic [MonthW-1:0] finish_month;
    logic [YearW-1:0]  finish_year;
  } dd_in_t;

  typedef struct packed {
    logic [CountW-1:0] day_count;
    status_t           status;
  } dd_out_t;

  // floor(v / 100) by reciprocal, exact for every 14-bit v
  function automatic logic [QuotW-1:0] div100(input logic [YearW-1:0] v);
    logic [26:0] prod;
    prod = 27'(v) * 27'd5243;
    return prod[19 +: QuotW];
  endfunction

  function automatic logic is_leap(input logic [YearW-1:0] y);
    logic [QuotW-1:0]  q;
    logic [YearW-1:0]  back;
    q    = div100(y);
    back = YearW'(q) * YearW'(100);
    return (y[1:0] == 2'd0) && ((back != y) || (q[1:0] == 2'd0));
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DayW'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                     len = DayW'(30);
      4'd2:                                        len = leap ? DayW'(29) : DayW'(28);
      default:                                     len = DayW'(0);
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before(input logic [MonthW-1:0] m);
    logic [8:0] n;
    unique case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

FILE: hdl/dd_date.sv
// Checks one date and forms its closed-form day number.
module dd_date (
  input  logic [dd_pkg::DayW-1:0]   day,
  input  logic [dd_pkg::MonthW-1:0] month,
  input  logic [dd_pkg::YearW-1:0]  year,
  output logic                      ok,
  output logic [dd_pkg::CountW-1:0] number
);
  import dd_pkg::*;

  logic             leap;
  logic [YearW-1:0] prev;
  logic [QuotW-1:0] cent;

  assign leap = is_leap(year);
  assign prev = year - YearW'(1);
  assign cent = div100(prev);

  assign ok = (day != '0) && (year != '0) && (year <= MaxYear) &&
              (month != '0) && (month <= MonthW'(12)) &&
              (day <= month_len(month, leap));

  // days before the year, before the month, then the day itself
  assign number = CountW'(prev) * CountW'(365)
                + CountW'(prev >> 2)
                - CountW'(cent)
                + CountW'(cent >> 2)
                + CountW'(days_before(month))
                + CountW'((month > MonthW'(2)) && leap)
                + CountW'(day);

endmodule

FILE: hdl/date_difference_days.sv
// Top level: days between two Gregorian dates, input register then result register.
//
//  channel  | valid        | ready        | payload
//  ---------+--------------+--------------+-----------------
//  in       | dates_valid  | dates_ready  | dates  (dd_in_t)
//  out      | result_valid | result_ready | result (dd_out_t)
//
// One item per cycle sustained while result_ready is high.
// Both dates are checked and numbered in one pass between the two registers.
// rst clears both valid flags; payload registers are not reset.
// A stall on the result side holds the result register, and the input register once full;
// the input register still takes an item when the result register frees in the same cycle.
module date_difference_days (
  input  logic           clk,
  input  logic           rst,
  input  logic           dates_valid,
  output logic           dates_ready,
  input  dd_pkg::dd_in_t dates,
  output logic           result_valid,
  input  logic           result_ready,
  output dd_pkg::dd_out_t result
);
  import dd_pkg::*;

  logic              s1_valid;
  dd_in_t            s1;
  logic              adv;
  logic              start_ok;
  logic              finish_ok;
  logic [CountW-1:0] start_num;
  logic [CountW-1:0] finish_num;
  dd_out_t           result_next;

  assign adv         = !result_valid || result_ready;
  assign dates_ready = !s1_valid || adv;

  dd_date u_start (
    .day    (s1.start_day),
    .month  (s1.start_month),
    .year   (s1.start_year),
    .ok     (start_ok),
    .number (start_num)
  );

  dd_date u_finish (
    .day    (s1.finish_day),
    .month  (s1.finish_month),
    .year   (s1.finish_year),
    .ok     (finish_ok),
    .number (finish_num)
  );

  always_comb begin
    result_next.day_count = '0;
    priority if (!start_ok) begin
      result_next.status = ST_START_BAD;
    end else if (!finish_ok) begin
      result_next.status = ST_FINISH_BAD;
    end else if (finish_num < start_num) begin
      result_next.status = ST_ORDER;
    end else begin
      result_next.status    = ST_OK;
      result_next.day_count = finish_num - start_num;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (dates_ready) begin
        s1_valid <= dates_valid;
      end
      if (adv) begin
        result_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dates_valid && dates_ready) begin
      s1 <= dates;
    end
    if (adv && s1_valid) begin
      result <= result_next;
    end
  end

  a_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status != ST_OK) |-> result.day_count == '0)
    else $error("day_count nonzero with error status");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    dates_valid && dates_ready |=> s1_valid)
    else $error("accepted item not held in input register");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv |=> s1_valid && $stable(s1))
    else $error("input register lost item during stall");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    s1_valid && adv |=> result_valid)
    else $error("item left input register without reaching result");

endmodule
